// ===== src/upd_pkg.sv =====
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned MAX_OUT = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]               cnt;
    logic [MAX_OUT-1:0][7:0]  data;
    logic                     last;
  } upd_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] v;
    u = (c >= 8'h61) ? (c - 8'h20) : c;
    v = (u >= 8'h41) ? (u - 8'h37) : (u - 8'h30);
    hex_value = v[3:0];
  endfunction

endpackage

// ===== src/upd_if.sv =====
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/url_percent_decoder.sv =====
// Streaming URL percent-decoder: one encoded byte in, zero to three decoded bytes out.
// Throughput: one input request per cycle unless the queue is full; output one byte
// per cycle while out_ready is high. Bytes go via the queue and the output register.
// A four-entry command queue between decoder front end and output serializer.
// Reset (synchronous, rst_n low): escape state idle, queue and output register empty.
module url_percent_decoder (
  input  logic     clk,
  input  logic     rst_n,
  upd_in_if.sink   in_chan,
  upd_out_if.source out_chan
);

  upd_pkg::upd_cmd_t push_cmd;
  upd_pkg::upd_cmd_t head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_byte  (in_chan.in_byte),
    .in_last  (in_chan.in_last),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.out_last)
  );

endmodule

// ===== src/upd_front.sv =====
module upd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             q_full,
  output logic             push,
  output upd_pkg::upd_cmd_t push_cmd
);

  upd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [3:0][7:0] slot;
  logic [1:0]      n;
  logic            normal;
  logic            accept;

  always_comb begin
    n         = '0;
    slot      = '0;
    normal    = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    case (phase_r)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::is_hex(in_byte)) begin
          held_nxt  = in_byte;
          phase_nxt = upd_pkg::PH_DIGIT;
        end else begin
          slot[n] = upd_pkg::CH_PERCENT;
          n       = n + 2'd1;
          normal  = 1'b1;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (upd_pkg::is_hex(in_byte)) begin
          slot[n]   = {upd_pkg::hex_value(held_r), upd_pkg::hex_value(in_byte)};
          n         = n + 2'd1;
          phase_nxt = upd_pkg::PH_IDLE;
        end else begin
          slot[n] = upd_pkg::CH_PERCENT;
          n       = n + 2'd1;
          slot[n] = held_r;
          n       = n + 2'd1;
          normal  = 1'b1;
        end
      end
      default: begin
        normal = 1'b1;
      end
    endcase

    if (normal) begin
      phase_nxt = upd_pkg::PH_IDLE;
      if (in_byte == upd_pkg::CH_PERCENT) begin
        phase_nxt = upd_pkg::PH_PCT;
      end else if (in_byte == upd_pkg::CH_PLUS) begin
        slot[n] = upd_pkg::CH_SPACE;
        n       = n + 2'd1;
      end else begin
        slot[n] = in_byte;
        n       = n + 2'd1;
      end
    end

    if (in_last) begin
      if (phase_nxt == upd_pkg::PH_PCT) begin
        slot[n] = upd_pkg::CH_PERCENT;
        n       = n + 2'd1;
      end else if (phase_nxt == upd_pkg::PH_DIGIT) begin
        slot[n] = upd_pkg::CH_PERCENT;
        n       = n + 2'd1;
        slot[n] = held_nxt;
        n       = n + 2'd1;
      end
      phase_nxt = upd_pkg::PH_IDLE;
    end
  end

  assign in_ready      = !q_full;
  assign accept        = in_valid && in_ready;
  assign push          = accept && (n != 2'd0);
  assign push_cmd.cnt  = n;
  assign push_cmd.data = slot[upd_pkg::MAX_OUT-1:0];
  assign push_cmd.last = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== src/upd_queue.sv =====
module upd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t push_cmd,
  input  logic              pop,
  output upd_pkg::upd_cmd_t head,
  output logic              full,
  output logic              empty
);

  upd_pkg::upd_cmd_t                 mem_r [upd_pkg::QDEPTH];
  logic [upd_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [upd_pkg::QPTR_W:0]          cnt_r;

  assign full  = (cnt_r == (upd_pkg::QPTR_W+1)'(upd_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/upd_back.sv =====
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  upd_pkg::upd_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       final_slot;

  assign load       = !empty && (!valid_r || out_ready);
  assign final_slot = (idx_r == (head.cnt - 2'd1));
  assign pop        = load && final_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= final_slot ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.data[idx_r];
      last_r <= head.last && final_slot;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// ===== dv/url_percent_decoder_tb.sv =====
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } decoded_t;

  class decode_scoreboard;
    decoded_t         expected_q[$];
    upd_pkg::phase_t  phase;
    logic [7:0]       held_char;
    int               failures;

    function new();
      phase = upd_pkg::PH_IDLE;
      held_char = '0;
      failures = 0;
    endfunction

    function bit hex_char(logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] t;
      if (c >= 8'h61) begin
        t = c - 8'h57;
      end else if (c >= 8'h41) begin
        t = c - 8'h37;
      end else begin
        t = c - 8'h30;
      end
      return t[3:0];
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("ERROR @%0t: %s", $time, msg);
      end
    endfunction

    // Predict the decoded bytes caused by one accepted request.
    function void take_request(logic [7:0] c, logic fin);
      logic [7:0] vals[$];
      bit         plain;
      plain = 0;
      case (phase)
        upd_pkg::PH_PCT: begin
          if (hex_char(c)) begin
            held_char = c;
            phase = upd_pkg::PH_DIGIT;
          end else begin
            vals.push_back(upd_pkg::CH_PERCENT);
            plain = 1;
          end
        end
        upd_pkg::PH_DIGIT: begin
          if (hex_char(c)) begin
            vals.push_back({nibble_of(held_char), nibble_of(c)});
            phase = upd_pkg::PH_IDLE;
          end else begin
            vals.push_back(upd_pkg::CH_PERCENT);
            vals.push_back(held_char);
            plain = 1;
          end
        end
        default: plain = 1;
      endcase
      if (plain) begin
        phase = upd_pkg::PH_IDLE;
        if (c == upd_pkg::CH_PERCENT) begin
          phase = upd_pkg::PH_PCT;
        end else if (c == upd_pkg::CH_PLUS) begin
          vals.push_back(upd_pkg::CH_SPACE);
        end else begin
          vals.push_back(c);
        end
      end
      if (fin) begin
        if (phase == upd_pkg::PH_PCT) begin
          vals.push_back(upd_pkg::CH_PERCENT);
        end else if (phase == upd_pkg::PH_DIGIT) begin
          vals.push_back(upd_pkg::CH_PERCENT);
          vals.push_back(held_char);
        end
        phase = upd_pkg::PH_IDLE;
      end
      foreach (vals[i]) begin
        expected_q.push_back('{vals[i], fin && (i == vals.size() - 1)});
      end
    endfunction

    function void check_result(logic [7:0] b, logic l);
      decoded_t exp;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected byte %h last %b", b, l));
        return;
      end
      exp = expected_q.pop_front();
      if (b !== exp.value || l !== exp.last) begin
        note_failure($sformatf("expected byte %h last %b, got byte %h last %b",
                               exp.value, exp.last, b, l));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  decode_scoreboard board;
  logic [7:0]       encoded_q[$];
  string            hex_set = "0123456789abcdefABCDEF";
  bit               in_calm;
  bit               out_calm;
  int               result_stall;
  int               random_sent;
  int               chunk_len;

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.out_byte, out_ch.out_last);
        result_stall = out_calm ? 0 : $urandom_range(0, 18);
      end else if (result_stall > 0) begin
        result_stall--;
      end
      out_ch.ready <= (result_stall == 0);
    end
  end

  task automatic send_request(logic [7:0] b, logic fin);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= fin;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    board.take_request(b, fin);
  endtask

  task automatic send_encoded();
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    foreach (encoded_q[i]) begin
      send_request(encoded_q[i], i == encoded_q.size() - 1);
    end
    encoded_q.delete();
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      encoded_q.push_back(s[i]);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hex();
    return hex_set[$urandom_range(0, hex_set.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (board.hex_char(b));
    return b;
  endfunction

  task automatic build_random_string();
    int tokens;
    int kind;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        encoded_q.push_back(upd_pkg::CH_PERCENT);
        encoded_q.push_back(pick_hex());
        encoded_q.push_back(pick_hex());
      end else if (kind < 55) begin
        encoded_q.push_back(upd_pkg::CH_PLUS);
      end else if (kind < 80) begin
        encoded_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 90) begin
        encoded_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // broken escape
        encoded_q.push_back(upd_pkg::CH_PERCENT);
        if ($urandom_range(0, 1)) encoded_q.push_back(pick_hex());
        if ($urandom_range(0, 2) != 0) encoded_q.push_back(pick_non_hex());
      end
    end
  endtask

  initial begin
    board        = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    random_sent  = 0;
    chunk_len    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_text("%7e+");
    send_encoded();
    queue_text("%zA%");
    send_encoded();
    queue_text("%4");
    send_encoded();
    queue_text("%0g");
    send_encoded();
    queue_text("%%41");
    send_encoded();
    queue_text("%Ff");
    send_encoded();
    encoded_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_encoded();
    wait_drained();

    while (random_sent < 96) begin
      build_random_string();
      chunk_len = encoded_q.size();
      random_sent += chunk_len;
      send_encoded();
      if (random_sent >= 48 && random_sent - chunk_len < 48) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (board.expected_q.size() != 0) begin
      board.note_failure($sformatf("%0d decoded bytes never arrived",
                                   board.expected_q.size()));
    end
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== url_percent_decoder.f =====
src/upd_pkg.sv
src/upd_if.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder.sv
dv/url_percent_decoder_tb.sv
